/* rtl/assert_macros.svh */
// Assertion macros used by the RTL files of the project.
// Compiling with ASSERT_OFF defined removes every assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// The property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// The condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif

`endif

/* rtl/aftm_pkg.sv */
`default_nettype none
package aftm_pkg;

   localparam int LEAF_SLOTS_DEF = 128;
   localparam int CONTEXTS_DEF   = 32;
   localparam int CHANNELS_DEF   = 2;
   localparam int VAR_W          = 48;

   localparam logic [15:0]      TOTAL_LIMIT  = 16'h8000;
   localparam logic [VAR_W-1:0] VAR_ONE      = 48'h0000_0001_0000;
   localparam logic [4:0]       BITS_RESET   = 5'd16;
   localparam logic [15:0]      WEIGHT_RESET = 16'd4096;

   // Register indexes, as decoded from paddr[2].
   localparam logic REG_SAMPLE_BITS  = 1'b0;
   localparam logic REG_WEIGHT_RECIP = 1'b1;

   typedef struct packed {
      logic signed [15:0] residual;
      logic               chan;
   } req_type;

   typedef struct packed {
      logic [4:0]  ctx_index;
      logic [14:0] cum_low;
      logic [14:0] sym_freq;
      logic [14:0] total_count;
      logic        is_top;
      logic [3:0]  extra_len;
      logic [11:0] extra_val;
   } rsp_type;

   typedef struct packed {
      logic             start;
      logic [15:0]      value;
      logic [VAR_W-1:0] variance;
      logic [15:0]      weight;
   } var_cmd_type;

   typedef struct packed {
      logic             done;
      logic [VAR_W-1:0] variance;
   } var_res_type;

endpackage
`default_nettype wire

/* rtl/aftm_var_unit.sv */
`default_nettype none
// Variance update: value*value*r + r + ((var*(65536-r)) >> 16), saturated.
// Start and operands pass through the a, b, c and d register stages to done.
module aftm_var_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  aftm_pkg::var_cmd_type cmd,
   output aftm_pkg::var_res_type res
);

   logic        a_v_ff, b_v_ff, c_v_ff, d_v_ff;
   logic [15:0] a_val_ff;
   logic [47:0] a_var_ff;
   logic [15:0] a_r_ff, b_r_ff, c_r_ff;
   logic [16:0] a_k_ff;
   logic [31:0] b_sq_ff;
   logic [40:0] b_plo_ff, b_phi_ff;
   logic [47:0] c_sqr_ff;
   logic [49:0] c_prod_ff;
   logic [47:0] d_res_ff;
   logic [65:0] prod_sum;
   logic [50:0] nv;

   assign prod_sum = {1'b0, b_phi_ff, 24'd0} + 66'(b_plo_ff);
   assign nv       = 51'(c_sqr_ff) + 51'(c_r_ff) + 51'(c_prod_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
         d_v_ff <= 1'b0;
      end else begin
         a_v_ff <= cmd.start;
         b_v_ff <= a_v_ff;
         c_v_ff <= b_v_ff;
         d_v_ff <= c_v_ff;
      end
      if (cmd.start) begin
         a_val_ff <= cmd.value;
         a_var_ff <= cmd.variance;
         a_r_ff   <= cmd.weight;
         a_k_ff   <= 17'h10000 - {1'b0, cmd.weight};
      end
      b_sq_ff   <= 32'(a_val_ff) * 32'(a_val_ff);
      b_plo_ff  <= 41'(a_var_ff[23:0]) * 41'(a_k_ff);
      b_phi_ff  <= 41'(a_var_ff[47:24]) * 41'(a_k_ff);
      b_r_ff    <= a_r_ff;
      c_sqr_ff  <= 48'(b_sq_ff) * 48'(b_r_ff);
      c_prod_ff <= prod_sum[65:16];
      c_r_ff    <= b_r_ff;
      d_res_ff  <= (nv[50:48] != 3'd0) ? {48{1'b1}} : nv[47:0];
   end

   assign res.done     = d_v_ff;
   assign res.variance = d_res_ff;

endmodule
`default_nettype wire

/* rtl/adaptive_frequency_tree_model_unit.sv */
`default_nettype none
// Adaptive frequency tree model. Each accepted residual beat is folded to
// zigzag form and split into a bucket symbol and raw extra bits; a context is
// chosen from the exponent of the selected channel's running variance, and
// that context's binary frequency tree, held in one synchronous memory, is
// walked from the root to give the cumulative low count, the symbol count
// and the context total in one result beat. The next item is accepted only
// once the result is loaded, which waits for the walk and for the variance
// update; a stalled result beat holds the unit. The walk issues one tree read
// per level on the single read port while the previous node, if the walk went
// left from it or it is the leaf, is written back, and the variance update
// runs alongside in a four-stage multiplier unit. When a context total plus
// two would reach 0x8000 the leaves are halved and the tree rebuilt through a
// scratch sum memory: each leaf is read and written back halved, then each
// internal node is rebuilt from its children, from the last one to the root;
// no item is taken meanwhile.
// After reset and after each sample_bits write, a sweep writes every entry of
// the tree memory, and no item is accepted until it ends. Register writes are
// taken at any time.
`include "assert_macros.svh"
module adaptive_frequency_tree_model_unit #(
   parameter int LEAF_SLOTS = aftm_pkg::LEAF_SLOTS_DEF,
   parameter int CONTEXTS   = aftm_pkg::CONTEXTS_DEF,
   parameter int CHANNELS   = aftm_pkg::CHANNELS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  aftm_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output aftm_pkg::rsp_type rsp_payload,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   localparam int LVL_MAX = $clog2(LEAF_SLOTS);
   localparam int NODE_W  = LVL_MAX + 1;
   localparam int LVL_W   = $clog2(NODE_W);
   localparam int CTX_W   = $clog2(CONTEXTS);
   localparam int ADDR_W  = CTX_W + NODE_W;
   localparam int MEM_D   = CONTEXTS * (2 ** NODE_W);
   localparam int SC_D    = 2 ** NODE_W;

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_LOAD, S_WALK, S_DRAIN, S_FIN, S_HRD, S_HWR, S_RRD, S_RWR
   } state_type;

   function automatic logic [3:0] msb16(input logic [15:0] v);
      logic [3:0] m;
      m = '0;
      for (int i = 0; i < 16; i++) if (v[i]) m = 4'(i);
      return m;
   endfunction

   function automatic logic [5:0] msb48(input logic [47:0] v);
      logic [5:0] m;
      m = '0;
      for (int i = 0; i < 48; i++) if (v[i]) m = 6'(i);
      return m;
   endfunction

   function automatic logic [LVL_W-1:0] msb_node(input logic [NODE_W-1:0] v);
      logic [LVL_W-1:0] m;
      m = '0;
      for (int i = 0; i < NODE_W; i++) if (v[i]) m = LVL_W'(i);
      return m;
   endfunction

   state_type             state_ff;
   logic [ADDR_W-1:0]     init_ff;
   logic [4:0]            sb_ff;
   logic [15:0]           wr_ff;
   logic [47:0]           var_ff [CHANNELS];
   logic                  var_busy_ff;
   logic                  rsp_valid_ff;
   aftm_pkg::rsp_type     rsp_ff;
   aftm_pkg::req_type     req_ff;
   logic                  ch_ff;
   logic [NODE_W-1:0]     target_ff, node_ff, pnode_ff, hi_ff, ri_ff;
   logic [CTX_W-1:0]      idx_ff;
   logic [3:0]            elen_ff;
   logic [11:0]           extra_ff;
   logic [LVL_W-1:0]      cnt_ff;
   logic [15:0]           acc_ff, leaf_ff;
   logic                  pend_v_ff, pleaf_ff, pright_ff;
   logic [15:0]           tot_ff [CONTEXTS];

   logic [15:0] tree_mem [MEM_D];
   logic [15:0] sc_mem [SC_D];
   logic [15:0] tree_rd_ff, sc_rd0_ff, sc_rd1_ff;

   // Settings that follow from the bit depth.
   logic [4:0]        eff_bits;
   logic [7:0]        ns_raw;
   logic [NODE_W-1:0] ns, ns_m1, nn;
   logic [LVL_W-1:0]  levels;
   logic [5:0]        nctx;

   always_comb begin
      eff_bits = (sb_ff == 5'd0) ? 5'd1 : ((sb_ff > 5'd16) ? 5'd16 : sb_ff);
      ns_raw   = (eff_bits < 5'd4) ? (8'd1 << eff_bits) : ({eff_bits, 3'b000} - 8'd16);
      ns       = (32'(ns_raw) > LEAF_SLOTS) ? NODE_W'(LEAF_SLOTS) : NODE_W'(ns_raw);
      ns_m1    = ns - NODE_W'(1);
      levels   = '0;
      for (int i = 0; i < NODE_W; i++) if (ns_m1[i]) levels = LVL_W'(i + 1);
      nn       = NODE_W'(1) << levels;
      nctx     = (32'({eff_bits, 1'b0}) > CONTEXTS) ? 6'(CONTEXTS) : {eff_bits, 1'b0};
   end

   // Symbol split of the captured residual.
   logic [15:0]       raw, value, rem;
   logic [3:0]        lg, group;
   logic [11:0]       mask12, extra;
   logic [2:0]        sym_lo;
   logic [7:0]        sym8;
   logic [3:0]        elen;
   logic [NODE_W-1:0] sym;

   always_comb begin
      raw    = req_ff.residual;
      value  = {raw[14:0] ^ {15{raw[15]}}, raw[15]};
      lg     = msb16(value);
      group  = lg - 4'd3;
      rem    = value & ~(16'd1 << lg);
      mask12 = (12'd1 << group) - 12'd1;
      sym_lo = 3'(rem >> group);
      if (value < 16'd8) begin
         sym8  = {5'd0, value[2:0]};
         elen  = 4'd0;
         extra = 12'd0;
      end else begin
         sym8  = 8'({group, 3'b000}) + 8'd8 + {5'd0, sym_lo};
         elen  = group;
         extra = rem[11:0] & mask12;
      end
      // A symbol past the used set is coded as the last used symbol.
      sym = (sym8 >= 8'(ns)) ? ns_m1 : NODE_W'(sym8);
   end

   // Context from the variance exponent, saturated to the last used context.
   logic [47:0] var_sel;
   logic [5:0]  var_msb, idx_raw;
   logic [CTX_W-1:0] idx_new;

   always_comb begin
      var_sel = var_ff[ch_ff];
      var_msb = msb48(var_sel);
      idx_raw = (var_sel < aftm_pkg::VAR_ONE) ? 6'd0 : (var_msb - 6'd16);
      idx_new = (idx_raw >= nctx) ? CTX_W'(nctx - 6'd1) : CTX_W'(idx_raw);
   end

   // Initial tree contents: a leaf holds 1 when used, an inner node holds the
   // number of used leaves in its left subtree.
   logic [NODE_W-1:0] in_node, in_start, in_h, in_diff, in_val;
   logic [LVL_W-1:0]  in_d, in_sh;

   always_comb begin
      in_node  = init_ff[NODE_W-1:0];
      in_d     = msb_node(in_node);
      in_sh    = levels - in_d;
      in_start = (in_node - (NODE_W'(1) << in_d)) << in_sh;
      in_h     = NODE_W'(1) << (in_sh - LVL_W'(1));
      in_diff  = ns - in_start;
      if (in_node == '0 || in_d > levels) begin
         in_val = '0;
      end else if (in_d == levels) begin
         in_val = ((in_node - nn) < ns) ? NODE_W'(1) : '0;
      end else if (ns <= in_start) begin
         in_val = '0;
      end else begin
         in_val = (in_diff > in_h) ? in_h : in_diff;
      end
   end

   // Walk direction and halving.
   logic [LVL_W-1:0] bit_pos;
   logic             go_right;
   logic [15:0]      half, sc_sum;

   assign bit_pos  = cnt_ff - LVL_W'(1);
   assign go_right = (cnt_ff != '0) && target_ff[bit_pos];
   assign half     = (tree_rd_ff == 16'd0) ? 16'd0 : (((tree_rd_ff - 16'd1) >> 1) + 16'd1);
   assign sc_sum   = sc_rd0_ff + sc_rd1_ff;

   // Result, totals and handshake decisions.
   logic [15:0]  total, tot2;
   logic         halve, fin_go, rsp_load, cfg_wr;
   logic         tot_we;
   logic [15:0]  tot_wd;

   assign total    = tot_ff[idx_ff];
   assign tot2     = total + 16'd2;
   assign halve    = (tot2 >= aftm_pkg::TOTAL_LIMIT);
   assign fin_go   = (state_ff == S_FIN) && !var_busy_ff && (!rsp_valid_ff || !rsp_stall);
   assign rsp_load = fin_go;
   assign cfg_wr   = psel && penable && pwrite;

   always_comb begin
      tot_we = 1'b0;
      tot_wd = tot2;
      if (fin_go && !halve) begin
         tot_we = 1'b1;
      end else if (state_ff == S_RWR && ri_ff == NODE_W'(1)) begin
         tot_we = 1'b1;
         tot_wd = sc_sum;
      end
   end

   // Memory port control.
   logic              tree_we;
   logic [ADDR_W-1:0] tree_wa, tree_ra;
   logic [15:0]       tree_wd;
   logic              sc_we;
   logic [NODE_W-1:0] sc_wa, sc_ra0, sc_ra1;
   logic [15:0]       sc_wd;

   always_comb begin
      tree_we = 1'b0;
      tree_wa = {idx_ff, pnode_ff};
      tree_wd = tree_rd_ff + 16'd2;
      tree_ra = {idx_ff, node_ff};
      sc_we   = 1'b0;
      sc_wa   = nn + hi_ff;
      sc_wd   = half;
      sc_ra0  = {ri_ff[NODE_W-2:0], 1'b0};
      sc_ra1  = {ri_ff[NODE_W-2:0], 1'b1};
      case (state_ff)
         S_INIT: begin
            tree_we = 1'b1;
            tree_wa = init_ff;
            tree_wd = 16'(in_val);
         end
         S_WALK, S_DRAIN: begin
            tree_we = pend_v_ff && (pleaf_ff || !pright_ff);
         end
         S_HRD: begin
            tree_ra = {idx_ff, nn + hi_ff};
         end
         S_HWR: begin
            tree_we = 1'b1;
            tree_wa = {idx_ff, nn + hi_ff};
            tree_wd = half;
            sc_we   = 1'b1;
         end
         S_RWR: begin
            tree_we = 1'b1;
            tree_wa = {idx_ff, ri_ff};
            tree_wd = sc_rd0_ff;
            sc_we   = 1'b1;
            sc_wa   = ri_ff;
            sc_wd   = sc_sum;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (tree_we) tree_mem[tree_wa] <= tree_wd;
      tree_rd_ff <= tree_mem[tree_ra];
   end

   always_ff @(posedge clock) begin
      if (sc_we) sc_mem[sc_wa] <= sc_wd;
      sc_rd0_ff <= sc_mem[sc_ra0];
      sc_rd1_ff <= sc_mem[sc_ra1];
   end

   // Variance unit.
   aftm_pkg::var_cmd_type var_cmd;
   aftm_pkg::var_res_type var_res;

   assign var_cmd.start    = (state_ff == S_LOAD);
   assign var_cmd.value    = value;
   assign var_cmd.variance = var_sel;
   assign var_cmd.weight   = wr_ff;

   aftm_var_unit u_var (
      .clock (clock),
      .reset (reset),
      .cmd   (var_cmd),
      .res   (var_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         init_ff      <= '0;
         sb_ff        <= aftm_pkg::BITS_RESET;
         wr_ff        <= aftm_pkg::WEIGHT_RESET;
         var_busy_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pend_v_ff    <= 1'b0;
         for (int c = 0; c < CHANNELS; c++) var_ff[c] <= aftm_pkg::VAR_ONE;
      end else begin
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         if (var_res.done) begin
            var_ff[ch_ff] <= var_res.variance;
            var_busy_ff   <= 1'b0;
         end
         if (tot_we) tot_ff[idx_ff] <= tot_wd;

         unique case (state_ff)
            S_INIT: begin
               for (int c = 0; c < CONTEXTS; c++) tot_ff[c] <= 16'(ns);
               if (init_ff == ADDR_W'(MEM_D - 1)) state_ff <= S_IDLE;
               init_ff <= init_ff + ADDR_W'(1);
            end
            S_IDLE: begin
               if (req_valid) begin
                  req_ff   <= req_payload;
                  ch_ff    <= (32'(req_payload.chan) >= CHANNELS) ? 1'(CHANNELS - 1)
                                                                 : req_payload.chan;
                  state_ff <= S_LOAD;
               end
            end
            S_LOAD: begin
               target_ff   <= nn + sym;
               idx_ff      <= idx_new;
               elen_ff     <= elen;
               extra_ff    <= extra;
               cnt_ff      <= levels;
               node_ff     <= NODE_W'(1);
               acc_ff      <= '0;
               pend_v_ff   <= 1'b0;
               var_busy_ff <= 1'b1;
               state_ff    <= S_WALK;
            end
            S_WALK: begin
               if (pend_v_ff && !pleaf_ff && pright_ff) acc_ff <= acc_ff + tree_rd_ff;
               pend_v_ff <= 1'b1;
               pnode_ff  <= node_ff;
               pleaf_ff  <= (cnt_ff == '0);
               pright_ff <= go_right;
               if (cnt_ff == '0) begin
                  state_ff <= S_DRAIN;
               end else begin
                  node_ff <= {node_ff[NODE_W-2:0], go_right};
                  cnt_ff  <= cnt_ff - LVL_W'(1);
               end
            end
            S_DRAIN: begin
               leaf_ff   <= tree_rd_ff;
               pend_v_ff <= 1'b0;
               state_ff  <= S_FIN;
            end
            S_FIN: begin
               if (fin_go) begin
                  rsp_valid_ff         <= 1'b1;
                  rsp_ff.ctx_index     <= 5'(idx_ff);
                  rsp_ff.cum_low       <= acc_ff[14:0];
                  rsp_ff.sym_freq      <= leaf_ff[14:0];
                  rsp_ff.total_count   <= total[14:0];
                  rsp_ff.is_top        <= ((17'(acc_ff) + 17'(leaf_ff)) == 17'(total));
                  rsp_ff.extra_len     <= elen_ff;
                  rsp_ff.extra_val     <= extra_ff;
                  hi_ff                <= '0;
                  state_ff             <= halve ? S_HRD : S_IDLE;
               end
            end
            S_HRD: begin
               state_ff <= S_HWR;
            end
            S_HWR: begin
               if (hi_ff == nn - NODE_W'(1)) begin
                  ri_ff    <= nn - NODE_W'(1);
                  state_ff <= S_RRD;
               end else begin
                  hi_ff    <= hi_ff + NODE_W'(1);
                  state_ff <= S_HRD;
               end
            end
            S_RRD: begin
               state_ff <= S_RWR;
            end
            S_RWR: begin
               if (ri_ff == NODE_W'(1)) begin
                  state_ff <= S_IDLE;
               end else begin
                  ri_ff    <= ri_ff - NODE_W'(1);
                  state_ff <= S_RRD;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase

         // Register writes; a new bit depth restarts the tree sweep.
         if (cfg_wr) begin
            case (paddr[2])
               aftm_pkg::REG_SAMPLE_BITS: begin
                  sb_ff    <= pwdata[4:0];
                  state_ff <= S_INIT;
                  init_ff  <= '0;
               end
               aftm_pkg::REG_WEIGHT_RECIP: begin
                  wr_ff <= pwdata[15:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_comb begin
      unique case (paddr[2])
         aftm_pkg::REG_SAMPLE_BITS:  prdata = {27'd0, sb_ff};
         aftm_pkg::REG_WEIGHT_RECIP: prdata = {16'd0, wr_ff};
         default:                    prdata = 32'd0;
      endcase
   end

   assign pready      = 1'b1;
   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `ASSERT_NEVER(a_tree_write_idle, clock, reset,
      tree_we && (state_ff == S_IDLE || state_ff == S_LOAD), "tree write while no work")
   `ASSERT_NEVER(a_total_limit, clock, reset,
      tot_we && (tot_wd >= aftm_pkg::TOTAL_LIMIT), "context total stored at limit")
   `ASSERT_NEVER(a_var_done_unexpected, clock, reset,
      var_res.done && !var_busy_ff, "variance result without a pending update")
   `ASSERT_NEVER(a_rsp_overwrite, clock, reset,
      rsp_load && rsp_valid_ff && rsp_stall, "result register overwritten")

endmodule
`default_nettype wire
